>>> rtl/ets_pkg.sv
// ----------------------------------------------------------------------------
// ets_pkg: shared types and constants of the elevator target selector.
// Holds the transfer payload structs, the direction codes and the scan
// chain types that pass between the floor cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ets_pkg;

  // Width of a floor number and of each request bitmap.
  localparam int unsigned FLOOR_W = 4;
  localparam int unsigned REQ_W   = 9;

  // Travel direction codes.
  typedef enum logic [1:0] {
    DIR_IDLE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  // One decision step as it arrives.
  typedef struct packed {
    logic [FLOOR_W-1:0] current_floor;
    logic [REQ_W-1:0]   hall_up_calls;
    logic [REQ_W-1:0]   hall_down_calls;
    logic [REQ_W-1:0]   cabin_calls;
  } in_item_t;

  // One decision result.
  typedef struct packed {
    logic [FLOOR_W-1:0] target_floor;
    logic [1:0]         travel_direction;
    logic               no_request;
  } out_item_t;

  // Result of one scan: whether a floor was found and which one.
  typedef struct packed {
    logic               found;
    logic [FLOOR_W-1:0] floor;
  } scan_t;

  // Scans that travel from the lowest floor upward (lowest match wins).
  typedef struct packed {
    scan_t upc_ge;   // up or cabin request at or above the car
    scan_t upc_any;  // up or cabin request anywhere
    scan_t any_ge;   // any request at or above the car
  } up_chain_t;

  // Scans that travel from the highest floor downward (highest match wins).
  typedef struct packed {
    scan_t dnc_le;   // down or cabin request at or below the car
    scan_t dnc_any;  // down or cabin request anywhere
    scan_t any_le;   // any request at or below the car
  } dn_chain_t;

endpackage

`default_nettype wire

>>> rtl/ets_floor_cell.sv
// ----------------------------------------------------------------------------
// ets_floor_cell: one floor of the request scan chain.
// Looks at the request bits of its own floor and passes the upward and
// downward scan results on to its neighbors, keeping the first match.
// ----------------------------------------------------------------------------
`default_nettype none

module ets_floor_cell #(
  parameter int unsigned FLOOR_NUM = 1
) (
  input  wire logic [ets_pkg::FLOOR_W-1:0] cur_floor,
  input  wire logic                        hall_up,
  input  wire logic                        hall_down,
  input  wire logic                        cabin,
  input  wire ets_pkg::up_chain_t          up_in,
  output ets_pkg::up_chain_t               up_out,
  input  wire ets_pkg::dn_chain_t          dn_in,
  output ets_pkg::dn_chain_t               dn_out
);

  localparam logic [ets_pkg::FLOOR_W-1:0] MyFloor = ets_pkg::FLOOR_W'(FLOOR_NUM);

  logic upc;
  logic dnc;
  logic any_req;
  logic ge_cur;
  logic le_cur;

  // Local request view of this floor.
  assign upc     = hall_up | cabin;
  assign dnc     = hall_down | cabin;
  assign any_req = hall_up | hall_down | cabin;
  assign ge_cur  = (MyFloor >= cur_floor);
  assign le_cur  = (MyFloor <= cur_floor);

  // Upward chain: an earlier (lower) match is kept.
  always_comb begin
    up_out = up_in;
    if (!up_in.upc_ge.found && upc && ge_cur) begin
      up_out.upc_ge = '{found: 1'b1, floor: MyFloor};
    end
    if (!up_in.upc_any.found && upc) begin
      up_out.upc_any = '{found: 1'b1, floor: MyFloor};
    end
    if (!up_in.any_ge.found && any_req && ge_cur) begin
      up_out.any_ge = '{found: 1'b1, floor: MyFloor};
    end
  end

  // Downward chain: an earlier (higher) match is kept.
  always_comb begin
    dn_out = dn_in;
    if (!dn_in.dnc_le.found && dnc && le_cur) begin
      dn_out.dnc_le = '{found: 1'b1, floor: MyFloor};
    end
    if (!dn_in.dnc_any.found && dnc) begin
      dn_out.dnc_any = '{found: 1'b1, floor: MyFloor};
    end
    if (!dn_in.any_le.found && any_req && le_cur) begin
      dn_out.any_le = '{found: 1'b1, floor: MyFloor};
    end
  end

endmodule

`default_nettype wire

>>> rtl/elevator_target_selector.sv
// A result is registered into the output register, or into the skid entry while the output is stalled.
// Throughput: one decision per cycle while the skid entry is empty; the direction
//   and target registers are updated in the same cycle by a single pass through the cells.
// A two-entry output buffer takes a new item while one result is stalled.
// Reset: direction idle, target floor 1, output buffer empty.
// ----------------------------------------------------------------------------
// elevator_target_selector: LOOK-style target floor selection.
// A row of floor cells scans the hall and cabin requests upward and
// downward; the top level picks the target and sets the travel direction.
// ----------------------------------------------------------------------------
`default_nettype none

module elevator_target_selector #(
  parameter int unsigned FLOOR_COUNT = 9
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ets_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ets_pkg::out_item_t       out_data
);

  localparam int unsigned CellCount =
      (FLOOR_COUNT < ets_pkg::REQ_W) ? FLOOR_COUNT : ets_pkg::REQ_W;
  localparam logic [ets_pkg::FLOOR_W-1:0] TopFloor = ets_pkg::FLOOR_W'(FLOOR_COUNT);
  localparam logic [ets_pkg::FLOOR_W-1:0] FirstFloor = ets_pkg::FLOOR_W'(1);

  ets_pkg::dir_t                 direction_r, direction_nxt;
  logic [ets_pkg::FLOOR_W-1:0]   target_r, target_nxt;
  logic                          none_nxt;
  logic [ets_pkg::FLOOR_W-1:0]   cur;
  ets_pkg::out_item_t            result;
  ets_pkg::out_item_t            out_r, skid_r;
  logic                          out_valid_r, skid_valid_r;
  logic                          in_xfer, out_xfer;

  ets_pkg::up_chain_t            up_c [0:CellCount];
  ets_pkg::dn_chain_t            dn_c [1:CellCount+1];
  ets_pkg::up_chain_t            up_res;
  ets_pkg::dn_chain_t            dn_res;

  // Clamp the car floor into the valid range.
  always_comb begin
    cur = in_data.current_floor;
    if (cur < FirstFloor) begin
      cur = FirstFloor;
    end else if (cur > TopFloor) begin
      cur = TopFloor;
    end
  end

  // Row of floor cells; the chains enter at the ends with nothing found.
  assign up_c[0]           = '0;
  assign dn_c[CellCount+1] = '0;

  for (genvar g = 1; g <= CellCount; g++) begin : g_cell
    ets_floor_cell #(
      .FLOOR_NUM (g)
    ) u_cell (
      .cur_floor (cur),
      .hall_up   (in_data.hall_up_calls[g-1]),
      .hall_down (in_data.hall_down_calls[g-1]),
      .cabin     (in_data.cabin_calls[g-1]),
      .up_in     (up_c[g-1]),
      .up_out    (up_c[g]),
      .dn_in     (dn_c[g+1]),
      .dn_out    (dn_c[g])
    );
  end

  assign up_res = up_c[CellCount];
  assign dn_res = dn_c[1];

  // Target selection for the stored direction.
  always_comb begin
    target_nxt = target_r;
    none_nxt   = 1'b0;
    unique case (direction_r)
      ets_pkg::DIR_UP: begin
        if (up_res.upc_ge.found) begin
          target_nxt = up_res.upc_ge.floor;
        end else if (dn_res.dnc_any.found) begin
          target_nxt = dn_res.dnc_any.floor;
        end else if (up_res.upc_any.found && (up_res.upc_any.floor < cur)) begin
          target_nxt = up_res.upc_any.floor;
        end
      end
      ets_pkg::DIR_DOWN: begin
        if (dn_res.dnc_le.found) begin
          target_nxt = dn_res.dnc_le.floor;
        end else if (up_res.upc_any.found) begin
          target_nxt = up_res.upc_any.floor;
        end else if (dn_res.dnc_any.found && (dn_res.dnc_any.floor > cur)) begin
          target_nxt = dn_res.dnc_any.floor;
        end
      end
      default: begin
        // Idle: nearest request, the lower floor on a tie.
        if (up_res.any_ge.found && dn_res.any_le.found) begin
          if ((up_res.any_ge.floor - cur) >= (cur - dn_res.any_le.floor)) begin
            target_nxt = dn_res.any_le.floor;
          end else begin
            target_nxt = up_res.any_ge.floor;
          end
        end else if (dn_res.any_le.found) begin
          target_nxt = dn_res.any_le.floor;
        end else if (up_res.any_ge.found) begin
          target_nxt = up_res.any_ge.floor;
        end else begin
          none_nxt = 1'b1;
        end
      end
    endcase
  end

  // Direction follows from the new target against the car floor.
  always_comb begin
    if (target_nxt < cur) begin
      direction_nxt = ets_pkg::DIR_DOWN;
    end else if (target_nxt > cur) begin
      direction_nxt = ets_pkg::DIR_UP;
    end else begin
      direction_nxt = ets_pkg::DIR_IDLE;
    end
  end

  assign result.target_floor     = target_nxt;
  assign result.travel_direction = direction_nxt;
  assign result.no_request       = none_nxt;

  // Handshake: the input stalls only while the skid entry is occupied.
  assign in_stall  = skid_valid_r;
  assign in_xfer   = in_valid && !skid_valid_r;
  assign out_xfer  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Scheduler state, updated on every input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= ets_pkg::DIR_IDLE;
      target_r    <= FirstFloor;
    end else if (in_xfer) begin
      direction_r <= direction_nxt;
      target_r    <= target_nxt;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_xfer) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_xfer) begin
      if (!out_valid_r || out_xfer) begin
        out_r       <= result;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= result;
        skid_valid_r <= 1'b1;
      end
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  // The skid entry only fills behind a result already in the output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds data while the output register is empty");

  // The stored target always names a real floor.
  a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
    (target_r != '0) && (target_r <= TopFloor))
    else $error("stored target floor out of range");

  // A transfer into a full, stalled output lands in the skid entry.
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && out_valid_r && out_stall) |=> skid_valid_r)
    else $error("result lost while the output was stalled");

  // A stored direction of up means the stored target was above the car.
  a_dir_match: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (direction_r == ets_pkg::DIR_UP) == (target_r > $past(cur)))
    else $error("direction does not match the target");
`endif

endmodule

`default_nettype wire
